// ===== hdl/lgs_pkg.sv =====
`default_nettype none
package lgs_pkg;

	localparam int ROW_W       = 16;
	localparam int ROW_NUM_W   = 4;
	localparam int DEF_ROWS    = 16;
	localparam int DEF_COLS    = 16;
	localparam int BIRTH_CNT   = 3;
	localparam int SURVIVE_LO  = 2;
	localparam int SURVIVE_HI  = 3;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FETCH,
		ST_SHIFT
	} lgs_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // store the incoming row
		logic start;  // clear window and fetch counter
		logic read;   // issue a grid read at the fetch index
		logic shift;  // advance the window, capture a result row when one is complete
	} lgs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic wr_last;
		logic fetch_end;
		logic fetch_zero;
		logic out_free;
	} lgs_status_t;

endpackage
`default_nettype wire

// ===== hdl/lgs_ram.sv =====
`default_nettype none
module lgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lgs_dp.sv =====
`default_nettype none
module lgs_dp #(
	parameter int GRID_ROWS = lgs_pkg::DEF_ROWS,
	parameter int GRID_COLS = lgs_pkg::DEF_COLS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lgs_pkg::lgs_cmd_t             cmd,
	output lgs_pkg::lgs_status_t               status,
	input  wire logic [lgs_pkg::ROW_W-1:0]     row_cells,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic      [lgs_pkg::ROW_W-1:0]     next_row_cells,
	output logic      [lgs_pkg::ROW_NUM_W-1:0] row_number,
	output logic                               last_row
);
	import lgs_pkg::*;

	localparam int AW = $clog2(GRID_ROWS);
	localparam int FW = $clog2(GRID_ROWS + 1);
	localparam logic [ROW_W-1:0] COL_MASK = (GRID_COLS >= ROW_W) ? {ROW_W{1'b1}} :
		ROW_W'((64'd1 << GRID_COLS) - 64'd1);

	function automatic logic [ROW_W-1:0] life_row(input logic [ROW_W-1:0] up,
		input logic [ROW_W-1:0] ctr, input logic [ROW_W-1:0] dn);
		logic [ROW_W-1:0] res;
		logic [3:0]       cnt;
		logic             l_up, l_ctr, l_dn, r_up, r_ctr, r_dn;
		res = '0;
		for (int j = 0; j < ROW_W; j++) begin
			l_up  = (j > 0) ? up[(j > 0) ? j - 1 : 0] : 1'b0;
			l_ctr = (j > 0) ? ctr[(j > 0) ? j - 1 : 0] : 1'b0;
			l_dn  = (j > 0) ? dn[(j > 0) ? j - 1 : 0] : 1'b0;
			r_up  = (j < ROW_W - 1) ? up[(j < ROW_W - 1) ? j + 1 : j] : 1'b0;
			r_ctr = (j < ROW_W - 1) ? ctr[(j < ROW_W - 1) ? j + 1 : j] : 1'b0;
			r_dn  = (j < ROW_W - 1) ? dn[(j < ROW_W - 1) ? j + 1 : j] : 1'b0;
			cnt = 4'(l_up) + 4'(up[j]) + 4'(r_up) + 4'(l_ctr) + 4'(r_ctr)
				+ 4'(l_dn) + 4'(dn[j]) + 4'(r_dn);
			if (ctr[j]) begin
				res[j] = (cnt >= 4'(SURVIVE_LO)) && (cnt <= 4'(SURVIVE_HI));
			end else begin
				res[j] = (cnt == 4'(BIRTH_CNT));
			end
		end
		return res;
	endfunction

	logic [AW-1:0]        wr_cnt_q;
	logic [FW-1:0]        fetch_q;
	logic [FW-1:0]        row_idx;
	logic [ROW_W-1:0]     mid_q, low_q;
	logic [ROW_W-1:0]     rd_data, shift_in, nxt;
	logic                 out_valid_q;
	logic [ROW_W-1:0]     out_cells_q;
	logic [ROW_NUM_W-1:0] out_num_q;
	logic                 out_last_q;

	lgs_ram #(
		.WIDTH(ROW_W),
		.DEPTH(GRID_ROWS)
	) u_grid (
		.clk    (clk),
		.wr_en  (cmd.load),
		.wr_addr(wr_cnt_q),
		.wr_data(row_cells & COL_MASK),
		.rd_en  (cmd.read),
		.rd_addr(fetch_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign status.wr_last    = (wr_cnt_q == AW'(GRID_ROWS - 1));
	assign status.fetch_end  = (fetch_q == FW'(GRID_ROWS));
	assign status.fetch_zero = (fetch_q == '0);
	assign status.out_free   = !out_valid_q || !out_stall;

	// below the bottom edge the grid is dead
	assign shift_in = status.fetch_end ? '0 : rd_data;
	// result for row fetch-1: mid_q above it, low_q the row itself, shift_in below it
	assign nxt      = life_row(mid_q, low_q, shift_in) & COL_MASK;
	assign row_idx  = fetch_q - FW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q    <= '0;
			fetch_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				wr_cnt_q <= status.wr_last ? '0 : wr_cnt_q + AW'(1);
			end
			if (cmd.start) begin
				fetch_q <= '0;
			end else if (cmd.shift) begin
				fetch_q <= fetch_q + FW'(1);
			end
			if (cmd.shift && !status.fetch_zero) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mid_q <= '0;
			low_q <= '0;
		end else if (cmd.shift) begin
			mid_q <= low_q;
			low_q <= shift_in;
		end
		if (cmd.shift && !status.fetch_zero) begin
			out_cells_q <= nxt;
			out_num_q   <= ROW_NUM_W'(row_idx);
			out_last_q  <= status.fetch_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign next_row_cells = out_cells_q;
	assign row_number     = out_num_q;
	assign last_row       = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/lgs_ctrl.sv =====
`default_nettype none
module lgs_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire lgs_pkg::lgs_status_t status,
	output lgs_pkg::lgs_cmd_t         cmd
);
	import lgs_pkg::*;

	lgs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.wr_last) begin
						cmd.start = 1'b1;
						state_d   = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.read = !status.fetch_end;
				state_d  = ST_SHIFT;
			end
			ST_SHIFT: begin
				// the first shift only primes the window, later ones need a free output
				if (status.fetch_zero || status.out_free) begin
					cmd.shift = 1'b1;
					state_d   = status.fetch_end ? ST_LOAD : ST_FETCH;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/life_grid_generation_step.sv =====
// One generation of the B3/S23 life rule over a GRID_ROWS x GRID_COLS grid.
// Input channel (in_valid/in_stall, row_cells): one transaction per grid row,
// rows 0..GRID_ROWS-1 in order; columns at or above GRID_COLS are dropped.
// Cells outside the grid count as dead, no wrap-around.
// Rows are taken one per cycle while a frame loads. After the last row the
// input is stalled while the new generation is produced.
// Output channel (out_valid/out_stall, next_row_cells, row_number, last_row):
// GRID_ROWS transactions, row 0 first, last_row set on the final one.
// After the last input row is taken, a priming read and window shift come
// before the first result; each result then takes one grid read and one
// window shift, through the single read port of the row store.
// A stalled output holds its register and stops the row sweep until taken;
// the next frame may load while the final result still waits.
// Reset returns to frame loading with the row count at zero and no result
// pending; the row store itself is not cleared.
`default_nettype none
module life_grid_generation_step #(
	parameter int GRID_ROWS = lgs_pkg::DEF_ROWS,
	parameter int GRID_COLS = lgs_pkg::DEF_COLS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [lgs_pkg::ROW_W-1:0]     row_cells,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [lgs_pkg::ROW_W-1:0]     next_row_cells,
	output logic      [lgs_pkg::ROW_NUM_W-1:0] row_number,
	output logic                               last_row
);
	import lgs_pkg::*;

	lgs_cmd_t    cmd;
	lgs_status_t status;

	lgs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	lgs_dp #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.row_cells     (row_cells),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.next_row_cells(next_row_cells),
		.row_number    (row_number),
		.last_row      (last_row)
	);

endmodule
`default_nettype wire

// ===== hdl/lgs_checker.sv =====
`default_nettype none
module lgs_checker #(
	parameter int GRID_ROWS = lgs_pkg::DEF_ROWS
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [lgs_pkg::ROW_W-1:0]     next_row_cells,
	input wire logic [lgs_pkg::ROW_NUM_W-1:0] row_number,
	input wire logic                          last_row
);
	import lgs_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(next_row_cells) && $stable(row_number)
			&& $stable(last_row))
		else $error("stalled result changed");

	// mid-generation the input side must be closed
	a_no_load_mid_gen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_row |-> in_stall)
		else $error("input open while a generation is being emitted");

	a_last_row_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_row |-> row_number == ROW_NUM_W'(GRID_ROWS - 1))
		else $error("last_row on wrong row number");

	// row numbers step by one within a generation
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=>
			!out_valid || row_number == $past(row_number) + ROW_NUM_W'(1))
		else $error("row numbers out of order");

endmodule

bind life_grid_generation_step lgs_checker #(.GRID_ROWS(GRID_ROWS)) u_lgs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.next_row_cells(next_row_cells),
	.row_number    (row_number),
	.last_row      (last_row)
);
`default_nettype wire
